// ===== src/ush_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ush_pkg
// Shared constants and types of the UTF-8 symbol histogram: table geometry,
// field widths, the controller/datapath command and status bundles and the
// result beat layout.
// ----------------------------------------------------------------------------
package ush_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DIST_W      = IDX_W + 1;

  // Field widths
  localparam int COUNT_WIDTH = 32;
  localparam int CP_W        = 21;
  localparam int BYTE_W      = 8;
  localparam int AVAIL_W     = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the input beat, decode, start a read
    logic scan_step;  // advance the table search by one entry
    logic fin_hit;    // bump the matched count, load the result
    logic fin_miss;   // append (or flag full), load the result
    logic fin_read;   // load the read-mode result
  } ush_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_mode;   // mode field of the input beat on offer
    logic hit;        // last fetched entry matches the code point
    logic scan_done;  // every stored entry compared, no match
    logic out_free;   // result register can take a new beat
  } ush_sts_t;

  // One result beat
  typedef struct packed {
    logic [CP_W-1:0]        char_code;
    logic [AVAIL_W-1:0]     used_bytes;
    logic [IDX_W-1:0]       entry_index;
    logic [COUNT_WIDTH-1:0] entry_count;
    logic                   new_entry;
    logic                   table_full;
    logic                   entry_valid;
    logic [DIST_W-1:0]      distinct_count;
    logic [COUNT_WIDTH-1:0] total_count;
  } ush_res_t;

endpackage

// ===== src/ush_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ush_in_if
// Input channel: one character window or one table read request per beat.
// ----------------------------------------------------------------------------
interface ush_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [ush_pkg::BYTE_W-1:0]      byte0;
  logic [ush_pkg::BYTE_W-1:0]      byte1;
  logic [ush_pkg::BYTE_W-1:0]      byte2;
  logic [ush_pkg::BYTE_W-1:0]      byte3;
  logic [ush_pkg::AVAIL_W-1:0]     bytes_available;
  logic [ush_pkg::IDX_W-1:0]       read_index;

  modport source (
    output valid, mode, byte0, byte1, byte2, byte3, bytes_available, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, byte0, byte1, byte2, byte3, bytes_available, read_index,
    output ready
  );
endinterface

// ===== src/ush_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ush_out_if
// Result channel: one histogram result per beat.
// ----------------------------------------------------------------------------
interface ush_out_if;
  logic                                valid;
  logic                                ready;
  logic [ush_pkg::CP_W-1:0]            char_code;
  logic [ush_pkg::AVAIL_W-1:0]         used_bytes;
  logic [ush_pkg::IDX_W-1:0]           entry_index;
  logic [ush_pkg::COUNT_WIDTH-1:0]     entry_count;
  logic                                new_entry;
  logic                                table_full;
  logic                                entry_valid;
  logic [ush_pkg::DIST_W-1:0]          distinct_count;
  logic [ush_pkg::COUNT_WIDTH-1:0]     total_count;

  modport source (
    output valid, char_code, used_bytes, entry_index, entry_count,
           new_entry, table_full, entry_valid, distinct_count, total_count,
    input  ready
  );
  modport sink (
    input  valid, char_code, used_bytes, entry_index, entry_count,
           new_entry, table_full, entry_valid, distinct_count, total_count,
    output ready
  );
endinterface

// ===== src/ush_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ush_ctrl
// Sequencer: accepts a beat, runs the table search or the table read, and
// finishes the item once the result register is free.
// ----------------------------------------------------------------------------
module ush_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ush_pkg::ush_sts_t sts,
  output ush_pkg::ush_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.capture   = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.req_mode ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          if (sts.out_free) begin
            cmd.fin_hit = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (sts.scan_done) begin
          if (sts.out_free) begin
            cmd.fin_miss = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.fin_read = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ush_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ush_datapath
// UTF-8 decode, symbol and count memories, search pointer, counters and the
// result register.
// ----------------------------------------------------------------------------
module ush_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beat payload
  input  logic                                in_mode,
  input  logic [ush_pkg::BYTE_W-1:0]          in_byte0,
  input  logic [ush_pkg::BYTE_W-1:0]          in_byte1,
  input  logic [ush_pkg::BYTE_W-1:0]          in_byte2,
  input  logic [ush_pkg::BYTE_W-1:0]          in_byte3,
  input  logic [ush_pkg::AVAIL_W-1:0]         in_bytes_available,
  input  logic [ush_pkg::IDX_W-1:0]           in_read_index,
  // result side
  output logic                                out_valid,
  input  logic                                out_ready,
  output ush_pkg::ush_res_t                   out_res,
  // controller
  input  ush_pkg::ush_cmd_t                   cmd,
  output ush_pkg::ush_sts_t                   sts
);

  localparam int IDX_W  = ush_pkg::IDX_W;
  localparam int DIST_W = ush_pkg::DIST_W;
  localparam int CNT_W  = ush_pkg::COUNT_WIDTH;
  localparam int CP_W   = ush_pkg::CP_W;

  // Table memories
  logic [CP_W-1:0]  sym_mem [ush_pkg::TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem [ush_pkg::TABLE_DEPTH];
  logic [CP_W-1:0]  sym_q_r;
  logic [CNT_W-1:0] cnt_q_r;

  // Item registers
  logic [CP_W-1:0]            cp_r;
  logic [ush_pkg::AVAIL_W-1:0] used_r;
  logic [IDX_W-1:0]           ridx_r;

  // Search pointer and fetch tag
  logic [DIST_W-1:0] scan_r;
  logic              pend_v_r;
  logic [IDX_W-1:0]  pend_idx_r;

  // Counters
  logic [DIST_W-1:0] distinct_r, distinct_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  // Result register
  logic              out_valid_r;
  ush_pkg::ush_res_t res_r, res_nxt;

  logic [CP_W-1:0]             dec_cp;
  logic [ush_pkg::AVAIL_W-1:0] dec_used;
  logic [10:0]                 v2;
  logic [15:0]                 v3;
  logic [CP_W-1:0]             v4;
  logic                        av2, av3, av4;

  logic              scan_issue;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              sym_we, cnt_we;
  logic [CNT_W-1:0]  cnt_wd;
  logic [CNT_W-1:0]  cnt_inc;
  logic              tbl_full;
  logic              rd_in_range;
  logic              load_out;

  // UTF-8 decode of the offered window; failures give the raw lead byte
  always_comb begin
    av2 = (in_bytes_available >= ush_pkg::AVAIL_W'(2));
    av3 = (in_bytes_available >= ush_pkg::AVAIL_W'(3));
    av4 = (in_bytes_available >= ush_pkg::AVAIL_W'(4));
    v2  = {in_byte0[4:0], in_byte1[5:0]};
    v3  = {in_byte0[3:0], in_byte1[5:0], in_byte2[5:0]};
    v4  = {in_byte0[2:0], in_byte1[5:0], in_byte2[5:0], in_byte3[5:0]};
    dec_cp   = CP_W'(in_byte0);
    dec_used = ush_pkg::AVAIL_W'(1);
    if (in_byte0[7:5] == 3'b110) begin
      if (av2 && (v2 >= 11'h080)) begin
        dec_cp   = CP_W'(v2);
        dec_used = ush_pkg::AVAIL_W'(2);
      end
    end else if (in_byte0[7:4] == 4'b1110) begin
      if (av3 && (v3 >= 16'h0800)) begin
        dec_cp   = CP_W'(v3);
        dec_used = ush_pkg::AVAIL_W'(3);
      end
    end else if (in_byte0[7:3] == 5'b11110) begin
      if (av4 && (v4 >= 21'h010000) && (v4 <= 21'h10FFFF)) begin
        dec_cp   = v4;
        dec_used = ush_pkg::AVAIL_W'(4);
      end
    end
  end

  // Search control
  assign scan_issue = cmd.scan_step && (scan_r < distinct_r);
  assign rd_en      = cmd.capture || scan_issue;
  assign rd_addr    = cmd.capture ? in_read_index : scan_r[IDX_W-1:0];

  assign sts.req_mode  = in_mode;
  assign sts.hit       = pend_v_r && (sym_q_r == cp_r);
  assign sts.scan_done = !pend_v_r && (scan_r >= distinct_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Update side
  assign tbl_full    = (distinct_r == DIST_W'(ush_pkg::TABLE_DEPTH));
  assign cnt_inc     = (cnt_q_r == '1) ? cnt_q_r : cnt_q_r + CNT_W'(1);
  assign wr_addr     = cmd.fin_hit ? pend_idx_r : distinct_r[IDX_W-1:0];
  assign sym_we      = cmd.fin_miss && !tbl_full;
  assign cnt_we      = cmd.fin_hit || sym_we;
  assign cnt_wd      = cmd.fin_hit ? cnt_inc : CNT_W'(1);
  assign rd_in_range = (DIST_W'(ridx_r) < distinct_r);
  assign load_out    = cmd.fin_hit || cmd.fin_miss || cmd.fin_read;

  // Symbol memory
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[wr_addr] <= cp_r;
    end
    if (rd_en) begin
      sym_q_r <= sym_mem[rd_addr];
    end
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
    if (rd_en) begin
      cnt_q_r <= cnt_mem[rd_addr];
    end
  end

  // Counter and result next values
  always_comb begin
    distinct_nxt = distinct_r;
    total_nxt    = total_r;
    if (cmd.fin_hit || cmd.fin_miss) begin
      total_nxt = (total_r == '1) ? total_r : total_r + CNT_W'(1);
    end
    if (sym_we) begin
      distinct_nxt = distinct_r + DIST_W'(1);
    end

    res_nxt                = '0;
    res_nxt.distinct_count = distinct_nxt;
    res_nxt.total_count    = total_nxt;
    if (cmd.fin_read) begin
      res_nxt.entry_index = ridx_r;
      res_nxt.entry_valid = rd_in_range;
      if (rd_in_range) begin
        res_nxt.char_code   = sym_q_r;
        res_nxt.entry_count = cnt_q_r;
      end
    end else begin
      res_nxt.char_code  = cp_r;
      res_nxt.used_bytes = used_r;
      if (cmd.fin_hit) begin
        res_nxt.entry_index = pend_idx_r;
        res_nxt.entry_count = cnt_inc;
      end else if (tbl_full) begin
        res_nxt.table_full = 1'b1;
      end else begin
        res_nxt.entry_index = distinct_r[IDX_W-1:0];
        res_nxt.entry_count = CNT_W'(1);
        res_nxt.new_entry   = 1'b1;
      end
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cp_r   <= dec_cp;
      used_r <= dec_used;
      ridx_r <= in_read_index;
    end
    if (scan_issue) begin
      pend_idx_r <= scan_r[IDX_W-1:0];
    end
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      pend_v_r    <= 1'b0;
      distinct_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_r   <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_v_r <= scan_issue;
        if (scan_issue) begin
          scan_r <= scan_r + DIST_W'(1);
        end
      end
      distinct_r <= distinct_nxt;
      total_r    <= total_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/utf8_symbol_histogram.sv =====
`timescale 1ns / 1ps
// Count mode: linear search, one stored entry fetched per cycle; a match ends it, a
// miss follows a compare of all N stored entries (N distinct stored, <= 4096); an
// empty table misses with no fetch. Read mode: memory read registered at accept.
// One item at a time: the next beat is taken in the cycle after the result loads; a
// result held by out_ready stalls the finishing item. Reset clears the distinct and
// total counters and the result valid, not the table; stale slots never reach results.
// ----------------------------------------------------------------------------
// utf8_symbol_histogram
// Decodes one UTF-8 character per beat and keeps a frequency table of the
// distinct code points in first-seen order; read beats return table entries.
// ----------------------------------------------------------------------------
module utf8_symbol_histogram (
  input  logic        clk,
  input  logic        rst_n,
  ush_in_if.sink      in_bus,
  ush_out_if.source   out_bus
);

  ush_pkg::ush_cmd_t cmd;
  ush_pkg::ush_sts_t sts;
  ush_pkg::ush_res_t res;
  logic              in_ready;
  logic              out_valid;

  ush_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ush_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_bus.mode),
    .in_byte0           (in_bus.byte0),
    .in_byte1           (in_bus.byte1),
    .in_byte2           (in_bus.byte2),
    .in_byte3           (in_bus.byte3),
    .in_bytes_available (in_bus.bytes_available),
    .in_read_index      (in_bus.read_index),
    .out_valid          (out_valid),
    .out_ready          (out_bus.ready),
    .out_res            (res),
    .cmd                (cmd),
    .sts                (sts)
  );

  // Channel hookup
  assign in_bus.ready           = in_ready;
  assign out_bus.valid          = out_valid;
  assign out_bus.char_code      = res.char_code;
  assign out_bus.used_bytes     = res.used_bytes;
  assign out_bus.entry_index    = res.entry_index;
  assign out_bus.entry_count    = res.entry_count;
  assign out_bus.new_entry      = res.new_entry;
  assign out_bus.table_full     = res.table_full;
  assign out_bus.entry_valid    = res.entry_valid;
  assign out_bus.distinct_count = res.distinct_count;
  assign out_bus.total_count    = res.total_count;

endmodule
